[sv/bmcf_pkg.sv]
// Shared definitions for the binary matrix canonical form block.
// Holds the column permutation table, the candidate word type and the pick rule.
// No dependencies.
`default_nettype none

package bmcf_pkg;

	localparam int ROW_COUNT_DEF = 8;
	localparam int COL_COUNT = 4;
	localparam int NIBBLE = 4;
	localparam int KEY_W = 32;
	localparam int PERM_COUNT = 24;
	localparam int GROUP_A = 4;
	localparam int WIN_A = PERM_COUNT / GROUP_A;
	localparam int GROUP_B = 3;
	localparam int WIN_B = WIN_A / GROUP_B;

	localparam logic [KEY_W-1:0] ALL_ONES = '1;

	// Destination bit of column c sits at bits [2c+1:2c].
	localparam logic [7:0] PERM_TABLE [PERM_COUNT] = '{
		8'b11_10_01_00, 8'b10_11_01_00, 8'b11_01_10_00, 8'b01_11_10_00,
		8'b10_01_11_00, 8'b01_10_11_00, 8'b11_10_00_01, 8'b10_11_00_01,
		8'b11_00_10_01, 8'b00_11_10_01, 8'b10_00_11_01, 8'b00_10_11_01,
		8'b11_01_00_10, 8'b01_11_00_10, 8'b11_00_01_10, 8'b00_11_01_10,
		8'b01_00_11_10, 8'b00_01_11_10, 8'b10_01_00_11, 8'b01_10_00_11,
		8'b10_00_01_11, 8'b00_10_01_11, 8'b01_00_10_11, 8'b00_01_10_11
	};

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] map;
	} cand_t;

	// The earlier candidate wins unless the later one is strictly smaller.
	function automatic cand_t pick(cand_t early, cand_t late);
		return (late.key < early.key) ? late : early;
	endfunction

endpackage

`default_nettype wire

[sv/bmcf_rank.sv]
// Permutes the columns of every row for all column permutations and ranks the rows.
// Uses bmcf_pkg for the permutation table.
`default_nettype none

module bmcf_rank #(
	parameter int ROW_COUNT = bmcf_pkg::ROW_COUNT_DEF,
	parameter int RW = $clog2(ROW_COUNT)
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        valid_s1,
	input  wire [4*ROW_COUNT-1:0]      key_s1,
	output logic                       valid_s2,
	output logic [3:0]                 pat_s2  [bmcf_pkg::PERM_COUNT][ROW_COUNT],
	output logic [RW-1:0]              rank_s2 [bmcf_pkg::PERM_COUNT][ROW_COUNT]
);

	logic [3:0]    pat_d  [bmcf_pkg::PERM_COUNT][ROW_COUNT];
	logic [RW-1:0] rank_d [bmcf_pkg::PERM_COUNT][ROW_COUNT];
	logic [3:0]    row_in [ROW_COUNT];
	logic          less;

	always_comb begin
		for (int i = 0; i < ROW_COUNT; i++) begin
			row_in[i] = key_s1[bmcf_pkg::NIBBLE*(ROW_COUNT-1-i) +: bmcf_pkg::NIBBLE];
		end
		for (int p = 0; p < bmcf_pkg::PERM_COUNT; p++) begin
			for (int i = 0; i < ROW_COUNT; i++) begin
				pat_d[p][i] = '0;
				for (int c = 0; c < bmcf_pkg::COL_COUNT; c++) begin
					pat_d[p][i][bmcf_pkg::PERM_TABLE[p][2*c +: 2]] = row_in[i][c];
				end
			end
		end
		less = 1'b0;
		for (int p = 0; p < bmcf_pkg::PERM_COUNT; p++) begin
			for (int i = 0; i < ROW_COUNT; i++) begin
				rank_d[p][i] = '0;
				for (int j = 0; j < ROW_COUNT; j++) begin
					less = (pat_d[p][j] < pat_d[p][i]) ||
						((pat_d[p][j] == pat_d[p][i]) && (j < i));
					rank_d[p][i] = rank_d[p][i] + RW'(less);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		pat_s2  <= pat_d;
		rank_s2 <= rank_d;
	end

endmodule

`default_nettype wire

[sv/bmcf_pack.sv]
// Places the ranked rows into a packed key and a row map for every permutation.
// Uses bmcf_pkg for the candidate type and widths.
`default_nettype none

module bmcf_pack #(
	parameter int ROW_COUNT = bmcf_pkg::ROW_COUNT_DEF,
	parameter int RW = $clog2(ROW_COUNT)
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    valid_s2,
	input  wire [3:0]              pat_s2  [bmcf_pkg::PERM_COUNT][ROW_COUNT],
	input  wire [RW-1:0]           rank_s2 [bmcf_pkg::PERM_COUNT][ROW_COUNT],
	output logic                   valid_s3,
	output bmcf_pkg::cand_t        cand_s3 [bmcf_pkg::PERM_COUNT]
);

	bmcf_pkg::cand_t cand_d [bmcf_pkg::PERM_COUNT];

	always_comb begin
		for (int p = 0; p < bmcf_pkg::PERM_COUNT; p++) begin
			cand_d[p].key = '0;
			cand_d[p].map = '0;
			for (int k = 0; k < ROW_COUNT; k++) begin
				for (int i = 0; i < ROW_COUNT; i++) begin
					if (rank_s2[p][i] == RW'(k)) begin
						cand_d[p].key[bmcf_pkg::NIBBLE*(ROW_COUNT-1-k) +: bmcf_pkg::NIBBLE] =
							cand_d[p].key[bmcf_pkg::NIBBLE*(ROW_COUNT-1-k) +: bmcf_pkg::NIBBLE] |
							pat_s2[p][i];
						cand_d[p].map[bmcf_pkg::NIBBLE*k +: bmcf_pkg::NIBBLE] =
							cand_d[p].map[bmcf_pkg::NIBBLE*k +: bmcf_pkg::NIBBLE] | 4'(i);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		cand_s3 <= cand_d;
	end

endmodule

`default_nettype wire

[sv/bmcf_min.sv]
// Registered tree that keeps the smallest candidate, earliest permutation on ties.
// Uses bmcf_pkg for the candidate type and the pick rule.
`default_nettype none

module bmcf_min (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      valid_s3,
	input  wire bmcf_pkg::cand_t     cand_s3 [bmcf_pkg::PERM_COUNT],
	output logic                     valid_s6,
	output bmcf_pkg::cand_t          best_s6
);

	logic            valid_s4;
	logic            valid_s5;
	bmcf_pkg::cand_t win_s4 [bmcf_pkg::WIN_A];
	bmcf_pkg::cand_t win_s5 [bmcf_pkg::WIN_B];
	bmcf_pkg::cand_t win_a  [bmcf_pkg::WIN_A];
	bmcf_pkg::cand_t win_b  [bmcf_pkg::WIN_B];
	bmcf_pkg::cand_t win_c;

	always_comb begin
		for (int g = 0; g < bmcf_pkg::WIN_A; g++) begin
			win_a[g] = bmcf_pkg::pick(
				bmcf_pkg::pick(cand_s3[4*g], cand_s3[4*g+1]),
				bmcf_pkg::pick(cand_s3[4*g+2], cand_s3[4*g+3]));
		end
		for (int h = 0; h < bmcf_pkg::WIN_B; h++) begin
			win_b[h] = bmcf_pkg::pick(
				bmcf_pkg::pick(win_s4[3*h], win_s4[3*h+1]), win_s4[3*h+2]);
		end
		win_c = bmcf_pkg::pick(win_s5[0], win_s5[1]);
		// A key that never drops below all ones leaves the map at zero.
		if (win_c.key == bmcf_pkg::ALL_ONES) begin
			win_c.map = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		win_s4  <= win_a;
		win_s5  <= win_b;
		best_s6 <= win_c;
	end

endmodule

`default_nettype wire

[sv/binary_matrix_canonical_form.sv]
// Top level of the binary matrix canonical form block.
// Instantiates bmcf_rank, bmcf_pack and bmcf_min; uses bmcf_pkg.
//
// The block takes one word per clock cycle and never raises busy. Every word
// gives one result on canonical_key and origin_row_map, marked by done for a
// single cycle. Six register stages lie between the accepted word and its
// result: the input register, the permute and rank stage, the packing stage
// and a three stage minimum tree over the twenty-four column permutations.
// Results leave in the order words came in.
`default_nettype none

module binary_matrix_canonical_form #(
	parameter int ROW_COUNT = bmcf_pkg::ROW_COUNT_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [31:0] matrix_key,
	output logic        done,
	output logic [31:0] canonical_key,
	output logic [31:0] origin_row_map
);

	localparam int RW = $clog2(ROW_COUNT);

	logic                  valid_s1;
	logic [4*ROW_COUNT-1:0] key_s1;
	logic                  valid_s2;
	logic [3:0]            pat_s2  [bmcf_pkg::PERM_COUNT][ROW_COUNT];
	logic [RW-1:0]         rank_s2 [bmcf_pkg::PERM_COUNT][ROW_COUNT];
	logic                  valid_s3;
	bmcf_pkg::cand_t       cand_s3 [bmcf_pkg::PERM_COUNT];
	logic                  valid_s6;
	bmcf_pkg::cand_t       best_s6;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		key_s1 <= matrix_key[4*ROW_COUNT-1:0];
	end

	bmcf_rank #(.ROW_COUNT(ROW_COUNT), .RW(RW)) u_rank (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.key_s1   (key_s1),
		.valid_s2 (valid_s2),
		.pat_s2   (pat_s2),
		.rank_s2  (rank_s2)
	);

	bmcf_pack #(.ROW_COUNT(ROW_COUNT), .RW(RW)) u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.pat_s2   (pat_s2),
		.rank_s2  (rank_s2),
		.valid_s3 (valid_s3),
		.cand_s3  (cand_s3)
	);

	bmcf_min u_min (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s3 (valid_s3),
		.cand_s3  (cand_s3),
		.valid_s6 (valid_s6),
		.best_s6  (best_s6)
	);

	assign done           = valid_s6;
	assign canonical_key  = best_s6.key;
	assign origin_row_map = best_s6.map;

endmodule

`default_nettype wire

[sv/bmcf_checker.sv]
// Port level checks for binary_matrix_canonical_form, attached with bind.
// Depends on the top level's ports, its ROW_COUNT parameter and bmcf_pkg for the default row count.
`default_nettype none

module bmcf_checker #(
	parameter int ROW_COUNT = bmcf_pkg::ROW_COUNT_DEF
) (
	input wire        clk,
	input wire        arst_n,
	input wire        start,
	input wire        busy,
	input wire        done,
	input wire [31:0] canonical_key,
	input wire [31:0] origin_row_map
);

	localparam int USED_W = 4 * ROW_COUNT;
	localparam logic [31:0] UNUSED_MASK = ~(32'hFFFF_FFFF >> (32 - USED_W));

	a_word_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##6 done)
		else $error("accepted word did not give a result");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##6 !done)
		else $error("result without an accepted word");

	a_all_ones_map: assert property (@(posedge clk) disable iff (!arst_n)
		done && (canonical_key == 32'hFFFF_FFFF) |-> (origin_row_map == 32'd0))
		else $error("all ones key with nonzero row map");

	a_unused_rows_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((canonical_key & UNUSED_MASK) == 32'd0) &&
			((origin_row_map & UNUSED_MASK) == 32'd0))
		else $error("unused rows of a result are not zero");

endmodule

bind binary_matrix_canonical_form bmcf_checker #(.ROW_COUNT(ROW_COUNT)) u_bmcf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.canonical_key  (canonical_key),
	.origin_row_map (origin_row_map)
);

`default_nettype wire

[tb/sv/tb_binary_matrix_canonical_form.sv]
// Self-checking testbench for binary_matrix_canonical_form; uses bmcf_pkg.
// Directed and shaped random matrix words are sent in bursts, and each result is
// checked against a predictor that searches all column permutations.
`timescale 1ns / 1ps

module tb_binary_matrix_canonical_form;

	localparam int ROWS = bmcf_pkg::ROW_COUNT_DEF;
	localparam int COLS = bmcf_pkg::COL_COUNT;
	localparam int RANDOM_WORDS = 1330;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 16;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [31:0] key;
		logic [31:0] map;
	} canon_word_t;

	logic        clk;
	logic        arst_n;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] matrix_key = '0;
	logic        done;
	logic [31:0] canonical_key;
	logic [31:0] origin_row_map;

	logic [31:0] matrix_backlog [$];
	canon_word_t canonical_due [$];
	int          fault_count = 0;
	int          quiet_cycles = 0;
	int          burst_left;
	int          gap_left;

	binary_matrix_canonical_form dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.matrix_key(matrix_key),
		.done(done),
		.canonical_key(canonical_key),
		.origin_row_map(origin_row_map)
	);

	// Tries every column order in lexicographic order and keeps the strictly
	// smallest packed key of the stably sorted rows.
	function automatic canon_word_t canonical_form_of(logic [31:0] word);
		logic [3:0]  row_bits [ROWS];
		logic [7:0]  slot [ROWS];
		logic [7:0]  held;
		logic [3:0]  moved;
		logic [31:0] cand_key;
		logic [31:0] cand_map;
		int          order [COLS];
		int          n, i, j, k, t;
		canon_word_t best;
		best.key = '1;
		best.map = '0;
		for (i = 0; i < ROWS; i++)
			row_bits[i] = word[4 * (ROWS - 1 - i) +: 4];
		for (i = 0; i < COLS; i++)
			order[i] = i;
		for (n = 0; n < bmcf_pkg::PERM_COUNT; n++) begin
			for (i = 0; i < ROWS; i++) begin
				moved = '0;
				for (k = 0; k < COLS; k++)
					if (row_bits[i][k])
						moved[order[k]] = 1'b1;
				slot[i] = {moved, 4'(i)};
			end
			for (i = 1; i < ROWS; i++) begin
				held = slot[i];
				k = i - 1;
				while (k >= 0 && slot[k] > held) begin
					slot[k + 1] = slot[k];
					k--;
				end
				slot[k + 1] = held;
			end
			cand_key = '0;
			cand_map = '0;
			for (i = 0; i < ROWS; i++) begin
				cand_key = {cand_key[27:0], slot[i][7:4]};
				cand_map[4 * i +: 4] = slot[i][3:0];
			end
			if (cand_key < best.key) begin
				best.key = cand_key;
				best.map = cand_map;
			end
			i = COLS - 2;
			while (i >= 0 && order[i] >= order[i + 1])
				i--;
			if (i >= 0) begin
				j = COLS - 1;
				while (order[j] <= order[i])
					j--;
				t = order[i]; order[i] = order[j]; order[j] = t;
				i++;
				j = COLS - 1;
				while (i < j) begin
					t = order[i]; order[i] = order[j]; order[j] = t;
					i++;
					j--;
				end
			end
		end
		return best;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			matrix_key <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				canonical_due.insert(canonical_due.size(), canonical_form_of(matrix_key));
			if (!(start && busy)) begin
				if (gap_left != 0) begin
					start <= 1'b0;
					matrix_key <= $urandom;
					gap_left <= gap_left - 1;
				end else if (matrix_backlog.size() != 0) begin
					start <= 1'b1;
					matrix_key <= matrix_backlog.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 48);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					start <= 1'b0;
					matrix_key <= $urandom;
				end
			end
		end
	end

	always @(posedge clk) begin
		canon_word_t want;
		if (arst_n) begin
			if (done) begin
				if (canonical_due.size() == 0) begin
					if (fault_count < REPORT_LIMIT)
						$display("unexpected word: canonical_key %h origin_row_map %h",
							canonical_key, origin_row_map);
					fault_count++;
				end else begin
					want = canonical_due.pop_front();
					if (canonical_key !== want.key || origin_row_map !== want.map) begin
						if (fault_count < REPORT_LIMIT)
							$display("mismatch: key %h/%h exp %h/%h got %h/%h", want.key,
								want.map, want.key, want.map, canonical_key, origin_row_map);
						fault_count++;
					end
				end
			end
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("binary_matrix_canonical_form regression: fail");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [31:0] word;
		logic [3:0]  pat_a;
		logic [3:0]  pat_b;
		int          n, r;
		logic [31:0] corner_words [20];
		corner_words = '{
			32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0000_0001, 32'h0123_4567, 32'h7654_3210,
			32'hFEDC_BA98, 32'h89AB_CDEF, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h1248_1248, 32'h8421_8421, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
			32'h1111_1111, 32'h8888_8888, 32'h36C9_A5C3, 32'hEDB7_7BDE
		};
		arst_n = 1'b0;
		foreach (corner_words[n])
			matrix_backlog.insert(matrix_backlog.size(), corner_words[n]);
		for (n = 0; n < RANDOM_WORDS; n++) begin
			case ($urandom_range(0, 3))
				0, 1: word = $urandom;
				2: begin
					pat_a = 4'($urandom);
					pat_b = 4'($urandom);
					for (r = 0; r < ROWS; r++)
						word[4 * r +: 4] = $urandom_range(0, 1) ? pat_a : pat_b;
				end
				default: begin
					for (r = 0; r < ROWS; r++)
						case ($urandom_range(0, 3))
							0: word[4 * r +: 4] = 4'h0;
							1: word[4 * r +: 4] = 4'hF;
							2: word[4 * r +: 4] = 4'(1 << $urandom_range(0, 3));
							default: word[4 * r +: 4] = 4'($urandom);
						endcase
				end
			endcase
			matrix_backlog.insert(matrix_backlog.size(), word);
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		while (matrix_backlog.size() != 0 || start)
			@(posedge clk);
		while (canonical_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0 && canonical_due.size() == 0)
			$display("binary_matrix_canonical_form regression: pass");
		else
			$display("binary_matrix_canonical_form regression: fail");
		$finish;
	end

endmodule

[binary_matrix_canonical_form.f]
sv/bmcf_pkg.sv
sv/bmcf_rank.sv
sv/bmcf_pack.sv
sv/bmcf_min.sv
sv/binary_matrix_canonical_form.sv
sv/bmcf_checker.sv
tb/sv/tb_binary_matrix_canonical_form.sv
